>>> hdl/polyphase_rational_resampler_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the polyphase rational resampler
// Immediate-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef POLYPHASE_RATIONAL_RESAMPLER_MACROS_SVH
`define POLYPHASE_RATIONAL_RESAMPLER_MACROS_SVH

`ifndef SYNTHESIS
`define PRR_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prr assertion failed");
`define PRR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prr assertion failed");
`else
`define PRR_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define PRR_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

>>> hdl/prr_pkg.sv
// ----------------------------------------------------------------------------
// Polyphase rational resampler package
// Widths, field offsets, codes and shared types.
// ----------------------------------------------------------------------------
package prr_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 18;
    localparam int TAPS        = 16;
    localparam int MAX_PHASES  = 16;
    localparam int DECIM_LIMIT = 16;
    localparam int FRAC_BITS   = 16;
    localparam int MAX_RESULTS = 16;

    localparam int TAP_W       = $clog2(TAPS);
    localparam int PHASE_W     = $clog2(MAX_PHASES);
    localparam int COEF_ADDR_W = PHASE_W + TAP_W;
    localparam int COEF_DEPTH  = MAX_PHASES * TAPS;

    localparam int FACTOR_W    = 5;
    localparam int FIELD_SEL_W = 4;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int IUO_W       = 5;

    localparam int PROD_W      = SAMPLE_W + COEF_W;
    localparam int ACC_W       = PROD_W + TAP_W;

    localparam int OFS_Q       = SAMPLE_W;
    localparam int OFS_PH      = 2 * SAMPLE_W;
    localparam int OFS_TAP     = OFS_PH + FIELD_SEL_W;
    localparam int OFS_COEF    = OFS_TAP + FIELD_SEL_W;
    localparam int S_TDATA_W   = ((OFS_COEF + COEF_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((2 * SAMPLE_W + 7) / 8) * 8;

    localparam int CFG_IDX_W   = 1;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_COEF   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_INTERP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DECIM  = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MAC   = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_EMIT  = 5'b10000
    } seq_state_t;

    typedef struct packed {
        logic valid;
        logic first;
    } mac_ctrl_t;

endpackage

>>> hdl/prr_delay_line.sv
// ----------------------------------------------------------------------------
// Sample delay line
// Complex shift register of TAPS entries, oldest at index 0, with a
// registered read port addressed by tap.
// ----------------------------------------------------------------------------
module prr_delay_line import prr_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             shift_en,
    input  sample_t          in_i,
    input  sample_t          in_q,
    input  logic [TAP_W-1:0] rd_idx,
    output sample_t          rd_i,
    output sample_t          rd_q
);

    sample_t dl_i_reg [TAPS];
    sample_t dl_q_reg [TAPS];
    sample_t rd_i_reg;
    sample_t rd_q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < TAPS; j++) begin
                dl_i_reg[j] <= '0;
                dl_q_reg[j] <= '0;
            end
        end else if (shift_en) begin
            for (int j = 0; j < TAPS - 1; j++) begin
                dl_i_reg[j] <= dl_i_reg[j+1];
                dl_q_reg[j] <= dl_q_reg[j+1];
            end
            dl_i_reg[TAPS-1] <= in_i;
            dl_q_reg[TAPS-1] <= in_q;
        end
    end

    always_ff @(posedge aclk) begin
        rd_i_reg <= dl_i_reg[rd_idx];
        rd_q_reg <= dl_q_reg[rd_idx];
    end

    assign rd_i = rd_i_reg;
    assign rd_q = rd_q_reg;

endmodule

>>> hdl/prr_coef_store.sv
// ----------------------------------------------------------------------------
// Coefficient store
// One write port and one registered read port over MAX_PHASES x TAPS
// coefficients, phase in the upper address bits.
// ----------------------------------------------------------------------------
module prr_coef_store import prr_pkg::*; (
    input  logic                   aclk,
    input  logic                   we,
    input  logic [COEF_ADDR_W-1:0] waddr,
    input  coef_t                  wdata,
    input  logic [COEF_ADDR_W-1:0] raddr,
    output coef_t                  rdata
);

    coef_t coef_mem [COEF_DEPTH];
    coef_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            coef_mem[waddr] <= wdata;
        end
        rdata_reg <= coef_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/prr_mac.sv
// ----------------------------------------------------------------------------
// Complex multiply-accumulate unit
// Registered products of one coefficient with the I and Q samples, exact
// accumulation, then truncation toward zero and saturation of the sums.
// ----------------------------------------------------------------------------
module prr_mac import prr_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  mac_ctrl_t ctrl,
    input  coef_t     coef,
    input  sample_t   samp_i,
    input  sample_t   samp_q,
    output sample_t   res_i,
    output sample_t   res_q
);

    localparam int SHR_W = ACC_W - FRAC_BITS;
    localparam logic signed [ACC_W-1:0] FRAC_MASK = ACC_W'((2 ** FRAC_BITS) - 1);
    localparam logic signed [SHR_W-1:0] SAT_HI    = SHR_W'((2 ** (SAMPLE_W - 1)) - 1);
    localparam logic signed [SHR_W-1:0] SAT_LO    = ~SAT_HI;

    mac_ctrl_t                 pipe_reg;
    logic signed [PROD_W-1:0]  prod_i_reg;
    logic signed [PROD_W-1:0]  prod_q_reg;
    logic signed [PROD_W-1:0]  prod_i_next;
    logic signed [PROD_W-1:0]  prod_q_next;
    logic signed [ACC_W-1:0]   acc_i_reg;
    logic signed [ACC_W-1:0]   acc_q_reg;
    logic signed [ACC_W-1:0]   acc_i_next;
    logic signed [ACC_W-1:0]   acc_q_next;

    function automatic sample_t finish(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] biased;
        logic signed [SHR_W-1:0] shifted;
        biased  = acc[ACC_W-1] ? (acc + FRAC_MASK) : acc;
        shifted = biased[ACC_W-1:FRAC_BITS];
        if (shifted > SAT_HI) begin
            shifted = SAT_HI;
        end else if (shifted < SAT_LO) begin
            shifted = SAT_LO;
        end
        return shifted[SAMPLE_W-1:0];
    endfunction

    assign prod_i_next = coef * samp_i;
    assign prod_q_next = coef * samp_q;

    always_comb begin
        if (pipe_reg.first) begin
            acc_i_next = ACC_W'(prod_i_reg);
            acc_q_next = ACC_W'(prod_q_reg);
        end else begin
            acc_i_next = acc_i_reg + ACC_W'(prod_i_reg);
            acc_q_next = acc_q_reg + ACC_W'(prod_q_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pipe_reg <= '0;
        end else begin
            pipe_reg <= ctrl;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.valid) begin
            prod_i_reg <= prod_i_next;
            prod_q_reg <= prod_q_next;
        end
        if (pipe_reg.valid) begin
            acc_i_reg <= acc_i_next;
            acc_q_reg <= acc_q_next;
        end
    end

    assign res_i = finish(acc_i_reg);
    assign res_q = finish(acc_q_reg);

endmodule

>>> hdl/polyphase_rational_resampler.sv
// ----------------------------------------------------------------------------
// Polyphase rational resampler
// Resamples a complex 16-bit stream by interp/decim with a polyphase FIR.
// ----------------------------------------------------------------------------
// Input items arrive on the s_ stream: tuser selects a sample (0) or a
// coefficient write (1). Load every coefficient row in use before samples
// flow. Results leave on the m_ stream; tlast marks the final result that
// one input sample produces. interp_factor and decim_factor are written on
// the cfg_ port while the block is idle; any write restarts the schedule.
// A coefficient write or a sample with no result due is taken while idle.
// A sample with results due then runs, per result, the MAC state (one tap
// per cycle through the single multiply-accumulate unit), the drain state,
// the subtract-based phase update, which takes interp from phase + decim
// until the rest is below interp, and the load of the output register.
// s_tready is high only between items. A stalled receiver holds the block
// in the load cycle until the output register frees; a finished result
// waits there while the next one is computed. Reset clears the delay line,
// the schedule and the output valid flag and sets both factors to 1.
// ----------------------------------------------------------------------------
`include "polyphase_rational_resampler_macros.svh"

module polyphase_rational_resampler import prr_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // sample_i, sample_q, coef_phase, coef_tap, coef_value, zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // mode
    input  logic [0:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // out_i, out_q
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FACTOR_W-1:0]  cfg_wdata
);

    seq_state_t           state_reg,   state_next;
    logic [PHASE_W-1:0]   phase_reg,   phase_next;
    logic [IUO_W-1:0]     iuo_reg,     iuo_next;
    logic [CNT_W-1:0]     out_cnt_reg, out_cnt_next;
    logic [TAP_W-1:0]     tap_reg,     tap_next;
    logic [FACTOR_W-1:0]  rem_reg,     rem_next;
    logic [FACTOR_W-1:0]  interp_reg,  interp_next;
    logic [FACTOR_W-1:0]  decim_reg,   decim_next;
    mac_ctrl_t            issue_reg,   issue_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic                 m_tlast_reg;
    sample_t              m_i_reg;
    sample_t              m_q_reg;

    logic                 s_accept;
    logic                 out_free;
    logic                 out_load;
    logic                 last_w;
    logic [FACTOR_W-1:0]  interp_eff;
    logic [FACTOR_W-1:0]  decim_eff;
    sample_t              in_i;
    sample_t              in_q;
    logic [FIELD_SEL_W-1:0] coef_phase;
    logic [FIELD_SEL_W-1:0] coef_tap;
    coef_t                coef_value;
    logic                 coef_we;
    logic                 shift_en;
    coef_t                coef_rd;
    sample_t              dl_rd_i;
    sample_t              dl_rd_q;
    sample_t              res_i;
    sample_t              res_q;

    assign in_i       = s_tdata[SAMPLE_W-1:0];
    assign in_q       = s_tdata[OFS_Q +: SAMPLE_W];
    assign coef_phase = s_tdata[OFS_PH +: FIELD_SEL_W];
    assign coef_tap   = s_tdata[OFS_TAP +: FIELD_SEL_W];
    assign coef_value = s_tdata[OFS_COEF +: COEF_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign coef_we  = s_accept && (s_tuser[0] == MODE_COEF)
                      && (coef_phase < MAX_PHASES) && (coef_tap < TAPS);
    assign shift_en = s_accept && (s_tuser[0] == MODE_SAMPLE);

    always_comb begin
        if (interp_reg == '0) begin
            interp_eff = FACTOR_W'(1);
        end else if (interp_reg > FACTOR_W'(MAX_PHASES)) begin
            interp_eff = FACTOR_W'(MAX_PHASES);
        end else begin
            interp_eff = interp_reg;
        end
        if (decim_reg == '0) begin
            decim_eff = FACTOR_W'(1);
        end else if (decim_reg > FACTOR_W'(DECIM_LIMIT)) begin
            decim_eff = FACTOR_W'(DECIM_LIMIT);
        end else begin
            decim_eff = decim_reg;
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = (state_reg == ST_EMIT) && out_free;
    assign last_w   = (iuo_reg != '0) || (out_cnt_reg == CNT_W'(MAX_RESULTS - 1));

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        iuo_next     = iuo_reg;
        out_cnt_next = out_cnt_reg;
        tap_next     = tap_reg;
        rem_next     = rem_reg;
        interp_next  = interp_reg;
        decim_next   = decim_reg;
        issue_next.valid = (state_reg == ST_MAC);
        issue_next.first = (tap_reg == '0);

        unique case (state_reg)
            ST_IDLE: begin
                if (shift_en) begin
                    if (FACTOR_W'(phase_reg) >= interp_eff) begin
                        phase_next = '0;
                    end
                    if (iuo_reg == '0) begin
                        tap_next     = '0;
                        out_cnt_next = '0;
                        state_next   = ST_MAC;
                    end else begin
                        iuo_next = iuo_reg - IUO_W'(1);
                    end
                end
            end
            ST_MAC: begin
                tap_next = tap_reg + TAP_W'(1);
                if (tap_reg == TAP_W'(TAPS - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                rem_next   = FACTOR_W'(phase_reg) + decim_eff;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (rem_reg >= interp_eff) begin
                    rem_next = rem_reg - interp_eff;
                    iuo_next = iuo_reg + IUO_W'(1);
                end else begin
                    phase_next = rem_reg[PHASE_W-1:0];
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    if (last_w) begin
                        if (iuo_reg != '0) begin
                            iuo_next = iuo_reg - IUO_W'(1);
                        end
                        state_next = ST_IDLE;
                    end else begin
                        out_cnt_next = out_cnt_reg + CNT_W'(1);
                        tap_next     = '0;
                        state_next   = ST_MAC;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_INTERP: interp_next = cfg_wdata;
                REG_DECIM:  decim_next  = cfg_wdata;
                default: begin
                end
            endcase
            phase_next = '0;
            iuo_next   = '0;
        end
    end

    always_comb begin
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            phase_reg    <= '0;
            iuo_reg      <= '0;
            out_cnt_reg  <= '0;
            tap_reg      <= '0;
            rem_reg      <= '0;
            interp_reg   <= FACTOR_W'(1);
            decim_reg    <= FACTOR_W'(1);
            issue_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            iuo_reg      <= iuo_next;
            out_cnt_reg  <= out_cnt_next;
            tap_reg      <= tap_next;
            rem_reg      <= rem_next;
            interp_reg   <= interp_next;
            decim_reg    <= decim_next;
            issue_reg    <= issue_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_i_reg     <= res_i;
            m_q_reg     <= res_q;
            m_tlast_reg <= last_w;
        end
    end

    prr_delay_line u_delay_line (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (shift_en),
        .in_i     (in_i),
        .in_q     (in_q),
        .rd_idx   (tap_reg),
        .rd_i     (dl_rd_i),
        .rd_q     (dl_rd_q)
    );

    prr_coef_store u_coef_store (
        .aclk  (aclk),
        .we    (coef_we),
        .waddr ({coef_phase[PHASE_W-1:0], coef_tap[TAP_W-1:0]}),
        .wdata (coef_value),
        .raddr ({phase_reg, tap_reg}),
        .rdata (coef_rd)
    );

    prr_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (issue_reg),
        .coef    (coef_rd),
        .samp_i  (dl_rd_i),
        .samp_q  (dl_rd_q),
        .res_i   (res_i),
        .res_q   (res_q)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({m_q_reg, m_i_reg});
    assign m_tlast  = m_tlast_reg;

    `PRR_ASSERT_NEXT(a_load_only_in_emit, aclk, aresetn,
        (state_reg != ST_EMIT) && !m_tvalid_reg, !m_tvalid_reg)
    `PRR_ASSERT_IMP(a_phase_in_range, aclk, aresetn,
        state_reg == ST_MAC, FACTOR_W'(phase_reg) < interp_eff)
    `PRR_ASSERT_NEXT(a_due_sample_starts_mac, aclk, aresetn,
        shift_en && (iuo_reg == '0), state_reg == ST_MAC)
    `PRR_ASSERT_IMP(a_result_cap, aclk, aresetn,
        state_reg == ST_EMIT, out_cnt_reg < CNT_W'(MAX_RESULTS))

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// Testbench for the polyphase rational resampler
// A directed table covers the reset rates, coefficient extremes, output
// saturation and truncation toward zero; random phases then sweep the rate
// registers (zero, max, above range) under random stalls on both streams.
// Every transfer is checked against the table or the polyphase predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import prr_pkg::*;

    localparam int LIMIT_CYCLES = 2000000;
    localparam int SETTLE       = 48;
    localparam int PHASE_ITEMS  = 12;

    typedef struct packed {
        sample_t re;
        sample_t im;
        logic    last;
    } cplx_out_t;

    typedef struct packed {
        logic       mode;
        sample_t    si;
        sample_t    sq;
        logic [3:0] ph;
        logic [3:0] tp;
        coef_t      cv;
        logic       chk;
        sample_t    ei;
        sample_t    eq;
    } probe_row_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [0:0]           s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [FACTOR_W-1:0]  cfg_wdata = '0;

    sample_t             line_i [TAPS]       = '{default: '0};
    sample_t             line_q [TAPS]       = '{default: '0};
    coef_t               coef_mem [COEF_DEPTH] = '{default: '0};
    bit                  coef_loaded [COEF_DEPTH];
    logic [FACTOR_W-1:0] interp_raw = 5'd1;
    logic [FACTOR_W-1:0] decim_raw  = 5'd1;
    int unsigned         next_phase  = 0;
    int unsigned         wait_inputs = 0;

    cplx_out_t   step_outputs [$];
    cplx_out_t   due_outputs [$];
    probe_row_t  seed_rows [25];
    int          mismatches = 0;
    int          cycles     = 0;
    bit          sender_calm = 1'b0;
    bit          sink_calm   = 1'b0;

    polyphase_rational_resampler dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int unsigned clamp_factor(logic [FACTOR_W-1:0] raw, int unsigned lim);
        if (raw == 0) return 1;
        if (raw > lim) return lim;
        return raw;
    endfunction

    function automatic sample_t scale_sat(longint acc);
        longint v;
        v = acc / (longint'(1) << FRAC_BITS);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return sample_t'(v);
    endfunction

    function automatic coef_t draw_coef();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1) ? coef_t'(131071) : coef_t'(-131072);
            1: return coef_t'($urandom);
            default: return coef_t'(int'($urandom_range(0, 8192)) - 4096);
        endcase
    endfunction

    function automatic sample_t draw_sample();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1) ? sample_t'(32767) : sample_t'(-32768);
            1: return sample_t'(int'($urandom_range(0, 64)) - 32);
            default: return sample_t'($urandom);
        endcase
    endfunction

    task automatic resample_step(input logic mode, input sample_t si, input sample_t sq,
                                 input logic [3:0] ph, input logic [3:0] tp, input coef_t cv);
        int unsigned p, q, t, n;
        longint acc_i, acc_q;
        step_outputs.delete();
        if (mode == MODE_COEF) begin
            coef_mem[{ph, tp}] = cv;
            coef_loaded[{ph, tp}] = 1'b1;
            return;
        end
        for (int k = 0; k < TAPS - 1; k++) begin
            line_i[k] = line_i[k+1];
            line_q[k] = line_q[k+1];
        end
        line_i[TAPS-1] = si;
        line_q[TAPS-1] = sq;
        p = clamp_factor(interp_raw, MAX_PHASES);
        q = clamp_factor(decim_raw, DECIM_LIMIT);
        if (next_phase >= p) next_phase = 0;
        n = 0;
        while (wait_inputs == 0 && n < MAX_RESULTS) begin
            acc_i = 0;
            acc_q = 0;
            for (int j = 0; j < TAPS; j++) begin
                acc_i += longint'(coef_mem[next_phase*TAPS + j]) * longint'(line_i[j]);
                acc_q += longint'(coef_mem[next_phase*TAPS + j]) * longint'(line_q[j]);
            end
            step_outputs.push_back('{scale_sat(acc_i), scale_sat(acc_q), 1'b0});
            n++;
            t = next_phase + q;
            wait_inputs += t / p;
            next_phase = t % p;
        end
        if (n > 0) step_outputs[n-1].last = 1'b1;
        if (wait_inputs > 0) wait_inputs--;
    endtask

    task automatic offer(input logic mode, input sample_t si, input sample_t sq,
                         input logic [3:0] ph, input logic [3:0] tp, input coef_t cv,
                         input logic chk, input sample_t ei, input sample_t eq);
        int gap;
        if ($urandom_range(0, 39) == 0) sender_calm = !sender_calm;
        gap = sender_calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {6'b0, cv, tp, ph, sq, si};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        resample_step(mode, si, sq, ph, tp, cv);
        if (chk) due_outputs.push_back('{ei, eq, 1'b1});
        else foreach (step_outputs[k]) due_outputs.push_back(step_outputs[k]);
    endtask

    task automatic set_rates(input logic [FACTOR_W-1:0] interp_v,
                             input logic [FACTOR_W-1:0] decim_v);
        s_tvalid <= 1'b0;
        while (due_outputs.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_INTERP;
        cfg_wdata <= interp_v;
        @(posedge aclk);
        cfg_index <= REG_DECIM;
        cfg_wdata <= decim_v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        interp_raw  = interp_v;
        decim_raw   = decim_v;
        next_phase  = 0;
        wait_inputs = 0;
    endtask

    initial begin
        logic [FACTOR_W-1:0] plan_interp [6];
        logic [FACTOR_W-1:0] plan_decim [6];
        logic [FACTOR_W-1:0] iv, dv;
        plan_interp = '{5'd2, 5'd16, 5'd0, 5'd1, 5'd31, 5'd5};
        plan_decim  = '{5'd3, 5'd1, 5'd0, 5'd16, 5'd31, 5'd7};
        seed_rows = '{
            '{MODE_COEF, 0, 0, 0, 0, 0, 1'b0, 0, 0},
            '{MODE_COEF, 0, 0, 0, 1, 0, 1'b0, 0, 0},
            '{MODE_COEF, 0, 0, 0, 2, 0, 1'b0, 0, 0},
            '{MODE_COEF, 0, 0, 0, 3, 0, 1'b0, 0, 0},
            '{MODE_COEF, 0, 0, 0, 4, 0, 1'b0, 0, 0},
            '{MODE_COEF, 0, 0, 0, 5, 0, 1'b0, 0, 0},
            '{MODE_COEF, 0, 0, 0, 6, 0, 1'b0, 0, 0},
            '{MODE_COEF, 0, 0, 0, 7, 0, 1'b0, 0, 0},
            '{MODE_COEF, 0, 0, 0, 8, 0, 1'b0, 0, 0},
            '{MODE_COEF, 0, 0, 0, 9, 0, 1'b0, 0, 0},
            '{MODE_COEF, 0, 0, 0, 10, 0, 1'b0, 0, 0},
            '{MODE_COEF, 0, 0, 0, 11, 0, 1'b0, 0, 0},
            '{MODE_COEF, 0, 0, 0, 12, 0, 1'b0, 0, 0},
            '{MODE_COEF, 0, 0, 0, 13, 0, 1'b0, 0, 0},
            '{MODE_COEF, 0, 0, 0, 14, 0, 1'b0, 0, 0},
            '{MODE_COEF, 0, 0, 0, 15, 65536, 1'b0, 0, 0},
            '{MODE_SAMPLE, 32767, -32768, 0, 0, 0, 1'b1, 32767, -32768},
            '{MODE_SAMPLE, -32768, 32767, 0, 0, 0, 1'b1, -32768, 32767},
            '{MODE_COEF, 0, 0, 0, 15, 131071, 1'b0, 0, 0},
            '{MODE_SAMPLE, 32767, -32768, 0, 0, 0, 1'b1, 32767, -32768},
            '{MODE_COEF, 0, 0, 0, 15, -131072, 1'b0, 0, 0},
            '{MODE_SAMPLE, 32767, -32768, 0, 0, 0, 1'b1, -32768, 32767},
            '{MODE_COEF, 0, 0, 0, 15, 1, 1'b0, 0, 0},
            '{MODE_SAMPLE, -1, 1, 0, 0, 0, 1'b1, 0, 0},
            '{MODE_SAMPLE, -32768, -32768, 0, 0, 0, 1'b1, 0, 0}
        };
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (seed_rows[r])
            offer(seed_rows[r].mode, seed_rows[r].si, seed_rows[r].sq, seed_rows[r].ph,
                  seed_rows[r].tp, seed_rows[r].cv, seed_rows[r].chk, seed_rows[r].ei,
                  seed_rows[r].eq);

        for (int pi = 0; pi < 8; pi++) begin
            if (pi < 6) begin
                iv = plan_interp[pi];
                dv = plan_decim[pi];
            end else begin
                iv = FACTOR_W'($urandom_range(0, 31));
                dv = FACTOR_W'($urandom_range(0, 31));
            end
            set_rates(iv, dv);
            for (int r = 0; r < clamp_factor(iv, MAX_PHASES); r++)
                for (int t = 0; t < TAPS; t++)
                    if (!coef_loaded[r*TAPS + t])
                        offer(MODE_COEF, draw_sample(), draw_sample(), 4'(r), 4'(t),
                              draw_coef(), 1'b0, '0, '0);
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 12)
                    offer(MODE_COEF, draw_sample(), draw_sample(), 4'($urandom_range(0, 15)),
                          4'($urandom_range(0, 15)), draw_coef(), 1'b0, '0, '0);
                else
                    offer(MODE_SAMPLE, draw_sample(), draw_sample(),
                          4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                          draw_coef(), 1'b0, '0, '0);
            end
        end

        s_tvalid <= 1'b0;
        while (due_outputs.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (mismatches == 0 && due_outputs.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int        gap;
        int        received;
        bit        held;
        cplx_out_t want;
        sample_t   got_i, got_q;
        received = 0;
        held     = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (received == 60 && !held) begin
                m_tready <= 1'b0;
                repeat (600) @(posedge aclk);
                held = 1'b1;
            end
            if ($urandom_range(0, 39) == 0) sink_calm = !sink_calm;
            gap = sink_calm ? 0 : $urandom_range(0, 4);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            received++;
            got_i = sample_t'(m_tdata[SAMPLE_W-1:0]);
            got_q = sample_t'(m_tdata[2*SAMPLE_W-1:SAMPLE_W]);
            if (due_outputs.size() == 0) begin
                mismatches++;
                $display("%0t: expected no transfer, got i=%0d q=%0d last=%0b",
                         $time, got_i, got_q, m_tlast);
            end else begin
                want = due_outputs.pop_front();
                if (got_i !== want.re || got_q !== want.im || m_tlast !== want.last) begin
                    mismatches++;
                    $display("%0t: expected i=%0d q=%0d last=%0b, got i=%0d q=%0d last=%0b",
                             $time, want.re, want.im, want.last, got_i, got_q, m_tlast);
                end
            end
        end
    end

endmodule
